FILE: rtl/base64url_stream_decoder_macros.svh
// Assertion macros for the base64url stream decoder checker.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef BASE64URL_STREAM_DECODER_MACROS_SVH
`define BASE64URL_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/b64sd_pkg.sv
// Shared types, constants and the character-to-sextet lookup for the
// base64url stream decoder. No dependencies.
package b64sd_pkg;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } b64sd_sextet_t;

  // Up to three results from one character, data[0] goes out first.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;     // results in this transaction group, 0..3
    logic            eos;     // group belongs to an end-of-string character
    logic            marker;  // single empty end marker
    logic            halted;  // marker of a halted string
  } b64sd_res_t;

  function automatic b64sd_sextet_t sextet_of(input logic [7:0] ch);
    b64sd_sextet_t s;
    s.bad = 1'b0;
    s.val = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      s.val = 6'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      s.val = 6'(ch - CH_LOWER_A) + SX_LOWER_BASE;
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      s.val = 6'(ch - CH_DIGIT_0) + SX_DIGIT_BASE;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      s.val = SX_PLUS;
    end else if (ch == CH_SLASH || ch == CH_UNDER) begin
      s.val = SX_SLASH;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

FILE: rtl/base64url_stream_decoder.sv
// Top level of the base64url stream decoder: input register, group decoder
// and result register. Depends on b64sd_pkg, b64sd_core and b64sd_outq.
//
// Decodes a base64url string (the standard '+' and '/' are taken as well)
// arriving one ASCII character per transaction, the last character flagged by
// in_end_of_string. Each full group of four characters gives up to three
// bytes; an invalid or '=' third symbol cuts the group to one byte, an invalid
// fourth to two, and an invalid first or second symbol halts the string: the
// rest of it is dropped and its end gives one empty marker (out_byte_present
// low) with out_decode_halted high. A partial group at the end of the string
// is handled as if padded with '='. Every end-of-string character yields at
// least one result; out_run_last marks the last result caused by a character
// and out_string_done the last result of the string. Timing: a character
// goes into an input register and is decoded from there; the decoder takes
// it when the result register is free or hands out its last result, or when
// the character has no result, and its results are then loaded into the
// result register, which drives the out_ ports. One character is taken per
// cycle unless a character with results waits for the result register; a
// character with k results holds the result register for k output
// transactions, while characters with no result keep flowing past it. Since
// four characters give at most three bytes, the sustained rate is one
// character per cycle with out_ready held high.
module base64url_stream_decoder
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_byte_present,
  output logic       out_run_last,
  output logic       out_string_done,
  output logic       out_decode_halted
);

  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_eos_r;
  logic       consume;
  logic       grp_free;
  b64sd_res_t res;

  // Input register frees up whenever the decoder takes its character.
  assign in_ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char;
      in_eos_r  <= in_end_of_string;
    end
  end

  b64sd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item_char (in_char_r),
    .item_eos  (in_eos_r),
    .grp_free  (grp_free),
    .consume   (consume),
    .res       (res)
  );

  // Only characters that produce results load the result register.
  b64sd_outq u_outq (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (consume && (res.cnt != 2'd0)),
    .res               (res),
    .out_ready         (out_ready),
    .grp_free          (grp_free),
    .out_valid         (out_valid),
    .out_data_byte     (out_data_byte),
    .out_byte_present  (out_byte_present),
    .out_run_last      (out_run_last),
    .out_string_done   (out_string_done),
    .out_decode_halted (out_decode_halted)
  );

endmodule

FILE: rtl/b64sd_core.sv
// Group decoder: holds the group-of-four state and turns one character into
// its result group. Depends on b64sd_pkg.
module b64sd_core
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_vld,
  input  logic [7:0] item_char,
  input  logic       item_eos,
  input  logic       grp_free,
  output logic       consume,
  output b64sd_res_t res
);

  typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_D} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [17:0]   held_r, held_nxt;
  logic          ti_r, ti_nxt;
  logic          halt_r, halt_nxt;
  b64sd_sextet_t sx;
  logic [5:0]    sa, sb, sc;

  assign sx = sextet_of(item_char);
  assign sa = held_r[17:12];
  assign sb = held_r[11:6];
  assign sc = held_r[5:0];

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    ti_nxt     = ti_r;
    halt_nxt   = halt_r;
    res.data   = '0;
    res.cnt    = 2'd0;
    res.eos    = item_eos;
    res.marker = 1'b0;
    res.halted = 1'b0;
    if (!halt_r) begin
      case (phase_r)
        PH_A: begin
          if (sx.bad) begin
            halt_nxt = 1'b1;
          end else begin
            held_nxt  = {sx.val, 12'd0};
            phase_nxt = PH_B;
            if (item_eos) halt_nxt = 1'b1;   // lone symbol: padded b is bad
          end
        end
        PH_B: begin
          if (sx.bad) begin
            halt_nxt = 1'b1;
          end else begin
            held_nxt[11:6] = sx.val;
            phase_nxt      = PH_C;
            if (item_eos) begin
              res.data[0] = {sa, sx.val[5:4]};
              res.cnt     = 2'd1;
            end
          end
        end
        PH_C: begin
          if (sx.bad) ti_nxt = 1'b1;
          else        held_nxt[5:0] = sx.val;
          phase_nxt = PH_D;
          if (item_eos) begin
            res.data[0] = {sa, sb[5:4]};
            res.cnt     = 2'd1;
            if (!ti_nxt) begin
              res.data[1] = {sb[3:0], sx.val[5:2]};
              res.cnt     = 2'd2;
            end
          end
        end
        default: begin
          res.data[0] = {sa, sb[5:4]};
          res.cnt     = 2'd1;
          if (!ti_r) begin
            res.data[1] = {sb[3:0], sc[5:2]};
            res.cnt     = 2'd2;
            if (!sx.bad) begin
              res.data[2] = {sc[1:0], sx.val};
              res.cnt     = 2'd3;
            end
          end
          phase_nxt = PH_A;
          held_nxt  = '0;
          ti_nxt    = 1'b0;
        end
      endcase
    end
    if (item_eos) begin
      if (res.cnt == 2'd0) begin
        res.cnt    = 2'd1;
        res.marker = 1'b1;
        res.halted = halt_nxt;
      end
      phase_nxt = PH_A;
      held_nxt  = '0;
      ti_nxt    = 1'b0;
      halt_nxt  = 1'b0;
    end
  end

  // A character with no results passes even while the result stage is busy.
  assign consume = item_vld && ((res.cnt == 2'd0) || grp_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_A;
      held_r  <= '0;
      ti_r    <= 1'b0;
      halt_r  <= 1'b0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      ti_r    <= ti_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

FILE: rtl/b64sd_outq.sv
// Result register: holds one result group and hands it out a byte per
// transaction. Depends on b64sd_pkg.
module b64sd_outq
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  b64sd_res_t res,
  input  logic       out_ready,
  output logic       grp_free,
  output logic       out_valid,
  output logic [7:0] out_data_byte,
  output logic       out_byte_present,
  output logic       out_run_last,
  output logic       out_string_done,
  output logic       out_decode_halted
);

  logic [2:0][7:0] data_r;
  logic [1:0]      cnt_r;
  logic            eos_r;
  logic            marker_r;
  logic            halted_r;
  logic            last;

  assign last      = (cnt_r == 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign grp_free  = (cnt_r == 2'd0) || (last && out_ready);

  assign out_data_byte     = data_r[0];
  assign out_byte_present  = !marker_r;
  assign out_run_last      = last;
  assign out_string_done   = last && eos_r;
  assign out_decode_halted = marker_r && halted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.cnt;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= res.data;
      eos_r    <= res.eos;
      marker_r <= res.marker;
      halted_r <= res.halted;
    end else if (out_valid && out_ready) begin
      data_r[0] <= data_r[1];
      data_r[1] <= data_r[2];
    end
  end

endmodule

FILE: rtl/b64sd_checker.sv
// Port-level checks for the base64url stream decoder, bound to the top level.
// Depends on base64url_stream_decoder_macros.svh.
`include "base64url_stream_decoder_macros.svh"

module b64sd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_present,
  input logic       out_run_last,
  input logic       out_string_done,
  input logic       out_decode_halted
);

  `B64SD_ASSERT_NOW(a_marker_ends_string, out_valid && !out_byte_present, out_run_last && out_string_done, "empty marker not at end of string")
  `B64SD_ASSERT_NOW(a_halt_on_marker, out_valid && out_decode_halted, !out_byte_present, "halt flag on a data byte")
  `B64SD_ASSERT_NOW(a_done_is_last, out_valid && out_string_done, out_run_last, "string end not on last result of its transaction")
  `B64SD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_run_last, out_valid && out_byte_present, "result group broken up")
  `B64SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_byte), "stalled result changed")

endmodule

bind base64url_stream_decoder b64sd_checker u_b64sd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_data_byte     (out_data_byte),
  .out_byte_present  (out_byte_present),
  .out_run_last      (out_run_last),
  .out_string_done   (out_string_done),
  .out_decode_halted (out_decode_halted)
);
